[rtl/core/cas_pkg.sv]
// Package for the cave automaton smoothing block: field widths, register
// indexes, reset values and the transfer types of both channels.
// Used by every module under rtl/core; depends on nothing.
package cas_pkg;

  // Default depth of the line stores (cells per row at most).
  localparam int unsigned MaxColsDefault = 512;

  // Fixed field and register widths.
  localparam int unsigned GridRowsW = 12;
  localparam int unsigned GridColsW = 10;
  localparam int unsigned ThreshW   = 4;
  localparam int unsigned OutRowW   = 12;
  localparam int unsigned OutColW   = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;

  // Register values after reset.
  localparam logic [GridRowsW-1:0] GridRowsReset = 12'd60;
  localparam logic [GridColsW-1:0] GridColsReset = 10'd120;
  localparam logic [ThreshW-1:0]   ThreshReset   = 4'd4;

  // Highest row count; the row counter saturates here.
  localparam logic [GridRowsW-1:0] RowSat = '1;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_ROWS      = 2'd0,
    CFG_GRID_COLS      = 2'd1,
    CFG_WALL_THRESHOLD = 2'd2
  } cfg_reg_e;

  // One input transfer.
  typedef struct packed {
    logic cell_is_wall;
    logic frame_start;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic               new_wall;
    logic [OutRowW-1:0] out_row;
    logic [OutColW-1:0] out_col;
    logic               frame_last;
  } out_item_t;

  // Per-cell information from the scan stage to the window stage.
  typedef struct packed {
    logic               wall;
    logic               emit;
    logic               last;
    logic [OutRowW-1:0] out_row;
    logic [OutColW-1:0] out_col;
  } scan_t;

endpackage

[rtl/core/cave_automaton_smoothing.sv]
// Cave smoothing filter: one generation of a wall/open cellular automaton.
// Depends on cas_pkg, cas_scan, cas_line_mem and cas_window.
//
// Cells stream in raster order, one per clock while in_stall_o is low; a
// cell marked frame_start is taken as row 0, column 0. The block keeps the
// two rows above the current cell in a line store memory of MAX_COLS
// entries and a 3x3 window in flip-flops. The result for interior cell
// (r,c) is computed when cell (r+1,c+1) moves on from the window stage and
// is then held in the output register until it is taken.
// Border cells are always wall and produce no result. The line store holds no
// reset value, so registers are to be changed only between frames. Stalls on
// the output back up into in_stall_o after one cell of slack.
module cave_automaton_smoothing import cas_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [GridRowsW-1:0] grid_rows_q;
  logic [GridColsW-1:0] grid_cols_q;
  logic [ThreshW-1:0]   wall_threshold_q;
  logic                 accept;
  scan_t                scan;
  logic [AddrW-1:0]     col;
  logic [1:0]           rd_data;
  logic                 wr_en;
  logic [AddrW-1:0]     wr_addr;
  logic [1:0]           wr_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q      <= GridRowsReset;
      grid_cols_q      <= GridColsReset;
      wall_threshold_q <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_GRID_ROWS:      grid_rows_q      <= cfg_wdata_i[GridRowsW-1:0];
        CFG_GRID_COLS:      grid_cols_q      <= cfg_wdata_i[GridColsW-1:0];
        CFG_WALL_THRESHOLD: wall_threshold_q <= cfg_wdata_i[ThreshW-1:0];
        default: begin
        end
      endcase
    end
  end

  cas_scan #(
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .grid_rows_i (grid_rows_q),
    .grid_cols_i (grid_cols_q),
    .col_o       (col),
    .scan_o      (scan)
  );

  cas_line_mem #(
    .MAX_COLS (MAX_COLS)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  cas_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .accept_o         (accept),
    .scan_i           (scan),
    .col_i            (col),
    .rd_data_i        (rd_data),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .wall_threshold_i (wall_threshold_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_o       (out_item_o)
  );

endmodule

[rtl/core/cas_line_mem.sv]
// Line store memory: one entry per column holding the two rows above the
// current one. Synchronous read with write forwarding.
// Depends on cas_pkg.
module cas_line_mem import cas_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDefault,
  localparam int unsigned AddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [1:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [1:0]       wr_data_i
);

  // Bit 1 holds the middle row, bit 0 the upper row.
  logic [1:0] mem_q [MAX_COLS];
  logic [1:0] rd_data_q;

  // Read port; a write to the same entry in the same cycle is passed through
  // so the read sees the value that the earlier cell leaves behind.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/cas_scan.sv]
// Scan stage: row and column counters, border forcing and the emit and
// last flags of each accepted cell. Depends on cas_pkg.
module cas_scan import cas_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDefault,
  localparam int unsigned AddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  in_item_t             in_item_i,
  input  logic [GridRowsW-1:0] grid_rows_i,
  input  logic [GridColsW-1:0] grid_cols_i,
  output logic [AddrW-1:0]     col_o,
  output scan_t                scan_o
);

  // Column arithmetic width: holds the clamped width and the column plus one.
  localparam int unsigned EffW = (AddrW + 1 > GridColsW) ? AddrW + 1 : GridColsW;
  localparam logic [EffW-1:0] MaxColsE = EffW'(MAX_COLS);

  logic [GridRowsW-1:0] row_q, row_d;
  logic [AddrW-1:0]     col_q, col_d;
  logic [GridRowsW-1:0] r;
  logic [AddrW-1:0]     c;
  logic [EffW-1:0]      cols, c_e, c_p1, c_m1;
  logic [GridRowsW:0]   r_p1;
  logic                 row_edge, col_edge;

  // Current position, with a frame start taken as the top-left cell.
  always_comb begin
    r    = in_item_i.frame_start ? '0 : row_q;
    c    = in_item_i.frame_start ? '0 : col_q;
    cols = (EffW'(grid_cols_i) > MaxColsE) ? MaxColsE : EffW'(grid_cols_i);
    c_e  = {{(EffW-AddrW){1'b0}}, c};
    c_p1 = c_e + 1'b1;
    c_m1 = c_e - 1'b1;
    r_p1 = {1'b0, r} + 1'b1;
    row_edge = (r == '0) || (r_p1 == {1'b0, grid_rows_i});
    col_edge = (c == '0) || (c_p1 == cols);
  end

  // Per-cell flags for the window stage.
  always_comb begin
    scan_o.wall    = in_item_i.cell_is_wall | row_edge | col_edge;
    scan_o.emit    = (r >= GridRowsW'(2)) && (c_e >= EffW'(2)) &&
                     (r < grid_rows_i) && (c_e < cols);
    scan_o.last    = (r_p1 == {1'b0, grid_rows_i}) && (c_p1 == cols);
    scan_o.out_row = r - 1'b1;
    scan_o.out_col = c_m1[OutColW-1:0];
    col_o          = c;
  end

  // Counter advance: wrap the column at the row end, saturate the row.
  always_comb begin
    if (c_p1 >= cols) begin
      col_d = '0;
      row_d = (r == RowSat) ? r : r + 1'b1;
    end else begin
      col_d = c_p1[AddrW-1:0];
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

[rtl/core/cas_window.sv]
// Window stage: takes the line store read, shifts the 3x3 window, counts
// neighbor walls, writes the stores back and holds the output register.
// Depends on cas_pkg.
module cas_window import cas_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDefault,
  localparam int unsigned AddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               accept_o,
  input  scan_t              scan_i,
  input  logic [AddrW-1:0]   col_i,
  input  logic [1:0]         rd_data_i,
  output logic               wr_en_o,
  output logic [AddrW-1:0]   wr_addr_o,
  output logic [1:0]         wr_data_o,
  input  logic [ThreshW-1:0] wall_threshold_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  logic             s1_valid_q;
  scan_t            s1_q;
  logic [AddrW-1:0] s1_col_q;
  logic             advance;
  logic [8:0]       win_q, win_d;
  logic [7:0]       nbrs;
  logic [3:0]       walls;
  logic             out_valid_q;
  out_item_t        out_q;

  // Handshake: the cell in flight moves on when the output register is free.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept_o   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      s1_q     <= scan_i;
      s1_col_q <= col_i;
    end
  end

  // New column: upper row in bit 0, middle in bit 1, current in bit 2.
  always_comb begin
    win_d = {s1_q.wall, rd_data_i[1], rd_data_i[0], win_q[8:3]};
    nbrs  = {win_d[8:5], win_d[3:0]};
    walls = '0;
    for (int i = 0; i < 8; i++) begin
      walls = walls + {3'b000, nbrs[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (advance) begin
      win_q <= win_d;
    end
  end

  // Write back: the middle row moves up and the current cell becomes middle.
  assign wr_en_o   = advance;
  assign wr_addr_o = s1_col_q;
  assign wr_data_o = {s1_q.wall, rd_data_i[1]};

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_q.emit) begin
      out_q.new_wall   <= ({1'b0, walls} >= {1'b0, wall_threshold_i});
      out_q.out_row    <= s1_q.out_row;
      out_q.out_col    <= s1_q.out_col;
      out_q.frame_last <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // An accepted cell always occupies the window stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept_o |=> s1_valid_q)
    else $error("accepted cell did not reach the window stage");

  // The stores are written only by a cell that is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en_o |-> s1_valid_q)
    else $error("line store written without a cell in flight");

  // A stalled result is never overwritten by the next cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !advance)
    else $error("window stage advanced over a stalled result");

  // A cell that left the window stage without a new one leaves it empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !accept_o) |=> !s1_valid_q)
    else $error("window stage kept a cell that had moved on");

endmodule
